// ===== rtl/dpac_pkg.sv =====
// ----------------------------------------------------------------------------
// dpac_pkg
// Shared types and constants for the dual PI attitude controller.
// ----------------------------------------------------------------------------
package dpac_pkg;

    localparam int ANGLE_W  = 16;
    localparam int ERR_W    = ANGLE_W + 1;
    localparam int GAIN_W   = 16;
    localparam int INTEG_W  = 32;
    localparam int MUL_A_W  = ERR_W;
    localparam int MUL_B_W  = INTEG_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int PTERM_W  = 34;
    localparam int SUM_W    = 39;
    localparam int INCR_W   = 34;
    localparam int CFG_AW   = 3;
    localparam int IN_W     = 6 * ANGLE_W;
    localparam int OUT_W    = 4 * ANGLE_W;

    localparam logic signed [ANGLE_W-1:0] RUDDER_CMD_DEFAULT = 16'sd0;

    localparam logic [GAIN_W-1:0]         PROP_GAIN_RST = 16'd256;
    localparam logic [GAIN_W-1:0]         INT_GAIN_RST  = 16'd0;
    localparam logic signed [ANGLE_W-1:0] LOWER_RST     = -16'sd2048;
    localparam logic signed [ANGLE_W-1:0] UPPER_RST     = 16'sd2048;

    typedef enum logic [CFG_AW-1:0] {
        REG_PITCH_KP = 3'd0,
        REG_PITCH_KI = 3'd1,
        REG_ROLL_KP  = 3'd2,
        REG_ROLL_KI  = 3'd3,
        REG_ELEV_LO  = 3'd4,
        REG_ELEV_HI  = 3'd5,
        REG_AIL_LO   = 3'd6,
        REG_AIL_HI   = 3'd7
    } dpac_reg_t;

    typedef enum logic [1:0] {
        MUL_KP,
        MUL_KI,
        MUL_DT
    } dpac_mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KP,
        ST_KI,
        ST_DT,
        ST_INTEG,
        ST_KI2,
        ST_CLAMP,
        ST_OUT
    } dpac_state_t;

    typedef struct packed {
        logic         in_load;
        logic         pterm_load;
        logic         u_load;
        logic         integ_upd;
        logic         cmd_load;
        logic         out_load;
        logic         loop_roll;
        dpac_mul_op_t mul_op;
    } dpac_cmd_t;

endpackage

// ===== rtl/dual_pi_attitude_controller.sv =====
// ----------------------------------------------------------------------------
// dual_pi_attitude_controller
// Pitch-to-elevator and roll-to-aileron PI loops with conditional integration.
// ----------------------------------------------------------------------------
// The input stream carries one sensor and target sample per transfer; the
// output stream returns one command set per input transfer, in order.
// Gains and limits are written through the cfg channel, which is always
// ready; writes are meant to happen while no sample is in flight.
// Both loops share one registered multiplier and run one after the other,
// pitch first and then roll, and a new input transfer is accepted only
// after both loops and the output step have finished. The output transfer
// is offered once the result has been loaded into the output register.
// The output sits in its own register, so the next sample is accepted while
// a finished result still waits. If the receiver stalls longer than one
// computation, the sequencer holds the new result in its final step and
// accepts no further input until the waiting transfer completes.
// Reset restores the default gains and limits and clears both integrators.
// The rudder field always carries the fixed trim value.
// ----------------------------------------------------------------------------
module dual_pi_attitude_controller
    import dpac_pkg::*;
#(
    parameter logic signed [ANGLE_W-1:0] RUDDER_CMD = RUDDER_CMD_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // roll_meas, pitch_meas, roll_target, pitch_target, throttle_target,
    // time_step
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // elevator_cmd, aileron_cmd, rudder_cmd, throttle_cmd
    output logic [OUT_W-1:0]    m_axis_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [GAIN_W-1:0]   cfg_data
);

    dpac_cmd_t cmd;

    assign cfg_ready = 1'b1;

    dpac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    dpac_datapath #(
        .RUDDER_CMD (RUDDER_CMD)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_we   (cfg_valid),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a sample is being computed");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a computation in progress");

    a_rudder_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:32] == RUDDER_CMD)
        else $error("rudder field differs from the trim value");

endmodule

// ===== rtl/dpac_datapath.sv =====
// ----------------------------------------------------------------------------
// dpac_datapath
// Gain and limit registers, integrators, one shared multiplier, the PI sum,
// clamp and the output data register.
// ----------------------------------------------------------------------------
module dpac_datapath
    import dpac_pkg::*;
#(
    parameter logic signed [ANGLE_W-1:0] RUDDER_CMD = RUDDER_CMD_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dpac_cmd_t           cmd,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [GAIN_W-1:0]   cfg_data,
    input  logic [IN_W-1:0]     in_data,
    output logic [OUT_W-1:0]    out_data
);

    logic [GAIN_W-1:0]         pitch_kp_reg;
    logic [GAIN_W-1:0]         pitch_ki_reg;
    logic [GAIN_W-1:0]         roll_kp_reg;
    logic [GAIN_W-1:0]         roll_ki_reg;
    logic signed [ANGLE_W-1:0] elev_lo_reg;
    logic signed [ANGLE_W-1:0] elev_hi_reg;
    logic signed [ANGLE_W-1:0] ail_lo_reg;
    logic signed [ANGLE_W-1:0] ail_hi_reg;

    logic signed [INTEG_W-1:0] pitch_int_reg;
    logic signed [INTEG_W-1:0] roll_int_reg;
    logic signed [INTEG_W-1:0] integ_next;

    logic signed [ERR_W-1:0]   pitch_err_reg;
    logic signed [ERR_W-1:0]   roll_err_reg;
    logic [ANGLE_W-1:0]        dt_reg;
    logic [ANGLE_W-1:0]        thr_reg;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PTERM_W-1:0] pterm_reg;
    logic signed [SUM_W-1:0]   u_reg;
    logic signed [SUM_W-1:0]   u_sum;
    logic signed [ANGLE_W-1:0] elev_reg;
    logic signed [ANGLE_W-1:0] ail_reg;
    logic signed [ANGLE_W-1:0] cmd_next;
    logic [OUT_W-1:0]          out_data_reg;

    logic signed [ERR_W-1:0]   err_cur;
    logic signed [INTEG_W-1:0] integ_cur;
    logic [GAIN_W-1:0]         kp_cur;
    logic [GAIN_W-1:0]         ki_cur;
    logic signed [ANGLE_W-1:0] lo_cur;
    logic signed [ANGLE_W-1:0] hi_cur;
    logic signed [SUM_W-1:0]   lo_q20;
    logic signed [SUM_W-1:0]   hi_q20;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [INCR_W-1:0]  integ_sum;
    logic                      u_above;
    logic                      u_below;
    logic                      do_integ;
    logic                      sum_above;
    logic                      sum_below;

    logic signed [ANGLE_W-1:0] roll_meas;
    logic signed [ANGLE_W-1:0] pitch_meas;
    logic signed [ANGLE_W-1:0] roll_target;
    logic signed [ANGLE_W-1:0] pitch_target;

    assign roll_meas    = in_data[15:0];
    assign pitch_meas   = in_data[31:16];
    assign roll_target  = in_data[47:32];
    assign pitch_target = in_data[63:48];

    always_comb
    begin
        err_cur   = cmd.loop_roll ? roll_err_reg : pitch_err_reg;
        integ_cur = cmd.loop_roll ? roll_int_reg : pitch_int_reg;
        kp_cur    = cmd.loop_roll ? roll_kp_reg  : pitch_kp_reg;
        ki_cur    = cmd.loop_roll ? roll_ki_reg  : pitch_ki_reg;
        lo_cur    = cmd.loop_roll ? ail_lo_reg   : elev_lo_reg;
        hi_cur    = cmd.loop_roll ? ail_hi_reg   : elev_hi_reg;
        lo_q20    = {{(SUM_W-ANGLE_W-8){lo_cur[ANGLE_W-1]}}, lo_cur, 8'd0};
        hi_q20    = {{(SUM_W-ANGLE_W-8){hi_cur[ANGLE_W-1]}}, hi_cur, 8'd0};
    end

    always_comb
    begin
        case (cmd.mul_op)
            MUL_KP:
            begin
                mul_a = {1'b0, kp_cur};
                mul_b = {{(MUL_B_W-ERR_W){err_cur[ERR_W-1]}}, err_cur};
            end
            MUL_KI:
            begin
                mul_a = {1'b0, ki_cur};
                mul_b = {integ_cur[INTEG_W-1], integ_cur};
            end
            MUL_DT:
            begin
                mul_a = err_cur;
                mul_b = {{(MUL_B_W-ANGLE_W){1'b0}}, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        u_sum = {{(SUM_W-PTERM_W){pterm_reg[PTERM_W-1]}}, pterm_reg}
              + {prod_reg[PROD_W-1], prod_reg[PROD_W-1:12]};

        u_above  = u_reg > hi_q20;
        u_below  = u_reg < lo_q20;
        do_integ = (!u_above && !u_below)
                || (u_above && err_cur[ERR_W-1])
                || (u_below && !err_cur[ERR_W-1] && (err_cur != '0));

        integ_sum = {{(INCR_W-INTEG_W){integ_cur[INTEG_W-1]}}, integ_cur}
                  + prod_reg[INCR_W+3:4];
        if (integ_sum[INCR_W-1:INTEG_W-1] == '0
            || integ_sum[INCR_W-1:INTEG_W-1] == '1)
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
        else if (integ_sum[INCR_W-1])
        begin
            integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
        end
        else
        begin
            integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
        end

        sum_above = u_sum > hi_q20;
        sum_below = u_sum < lo_q20;
        if (sum_above)
        begin
            cmd_next = hi_cur;
        end
        else if (sum_below)
        begin
            cmd_next = lo_cur;
        end
        else
        begin
            cmd_next = u_sum[ANGLE_W+7:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_kp_reg  <= PROP_GAIN_RST;
            pitch_ki_reg  <= INT_GAIN_RST;
            roll_kp_reg   <= PROP_GAIN_RST;
            roll_ki_reg   <= INT_GAIN_RST;
            elev_lo_reg   <= LOWER_RST;
            elev_hi_reg   <= UPPER_RST;
            ail_lo_reg    <= LOWER_RST;
            ail_hi_reg    <= UPPER_RST;
            pitch_int_reg <= '0;
            roll_int_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (dpac_reg_t'(cfg_addr))
                    REG_PITCH_KP: pitch_kp_reg <= cfg_data;
                    REG_PITCH_KI: pitch_ki_reg <= cfg_data;
                    REG_ROLL_KP:  roll_kp_reg  <= cfg_data;
                    REG_ROLL_KI:  roll_ki_reg  <= cfg_data;
                    REG_ELEV_LO:  elev_lo_reg  <= cfg_data;
                    REG_ELEV_HI:  elev_hi_reg  <= cfg_data;
                    REG_AIL_LO:   ail_lo_reg   <= cfg_data;
                    REG_AIL_HI:   ail_hi_reg   <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.integ_upd && do_integ)
            begin
                if (cmd.loop_roll)
                begin
                    roll_int_reg <= integ_next;
                end
                else
                begin
                    pitch_int_reg <= integ_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.in_load)
        begin
            pitch_err_reg <= {pitch_target[ANGLE_W-1], pitch_target}
                           - {pitch_meas[ANGLE_W-1], pitch_meas};
            roll_err_reg  <= {roll_target[ANGLE_W-1], roll_target}
                           - {roll_meas[ANGLE_W-1], roll_meas};
            thr_reg       <= in_data[79:64];
            dt_reg        <= in_data[95:80];
        end
        if (cmd.pterm_load)
        begin
            pterm_reg <= prod_reg[PTERM_W-1:0];
        end
        if (cmd.u_load)
        begin
            u_reg <= u_sum;
        end
        if (cmd.cmd_load)
        begin
            if (cmd.loop_roll)
            begin
                ail_reg <= cmd_next;
            end
            else
            begin
                elev_reg <= cmd_next;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {thr_reg, RUDDER_CMD, ail_reg, elev_reg};
        end
    end

    assign out_data = out_data_reg;

endmodule

// ===== rtl/dpac_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpac_ctrl
// Sequencer for the two PI loops and owner of the stream handshakes.
// ----------------------------------------------------------------------------
module dpac_ctrl
    import dpac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output dpac_cmd_t cmd
);

    dpac_state_t state_reg;
    dpac_state_t state_next;
    logic        loop_reg;
    logic        loop_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loop_reg      <= loop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        loop_next      = loop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.loop_roll  = loop_reg;
        cmd.mul_op     = MUL_KP;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    loop_next   = 1'b0;
                    state_next  = ST_KP;
                end
            end
            ST_KP:
            begin
                cmd.mul_op = MUL_KP;
                state_next = ST_KI;
            end
            ST_KI:
            begin
                cmd.pterm_load = 1'b1;
                cmd.mul_op     = MUL_KI;
                state_next     = ST_DT;
            end
            ST_DT:
            begin
                cmd.u_load = 1'b1;
                cmd.mul_op = MUL_DT;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.integ_upd = 1'b1;
                state_next    = ST_KI2;
            end
            ST_KI2:
            begin
                cmd.mul_op = MUL_KI;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.cmd_load = 1'b1;
                if (loop_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    loop_next  = 1'b1;
                    state_next = ST_KP;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
